FILE: rtl/core/rdws_pkg.sv
package rdws_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = IDX_W + 2;
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      OP_INS_FRONT = 2'd0,
      OP_INS_BACK  = 2'd1,
      OP_LIST      = 2'd2,
      OP_SEARCH    = 2'd3
   } rdws_op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_LISTED    = 3'd5
   } rdws_status_type;

   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic                     rd_en;
      logic [IDX_W-1:0]         rd_addr;
   } rdws_mem_req_type;

   typedef struct packed {
      rdws_status_type          status;
      logic signed [DATA_W-1:0] data;
      logic                     last;
   } rdws_rslt_type;

   // wrap base + offset into the ring; offset never exceeds CAPACITY
   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/core/rdws_store.sv
module rdws_store (
   input  logic                                clock,
   input  rdws_pkg::rdws_mem_req_type          mem_req,
   output logic signed [rdws_pkg::DATA_W-1:0]  rd_data
);

   logic signed [rdws_pkg::DATA_W-1:0] store_ff [rdws_pkg::CAPACITY];
   logic signed [rdws_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      // hold read data until the next read
      if (mem_req.rd_en) begin
         rd_data_ff <= store_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rdws_ctrl.sv
module rdws_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [1:0]                          req_op,
   input  logic signed [rdws_pkg::DATA_W-1:0]  req_value,
   input  logic                                out_free,
   input  logic signed [rdws_pkg::DATA_W-1:0]  rd_data,
   output rdws_pkg::rdws_mem_req_type          mem_req,
   output logic                                push_valid,
   output rdws_pkg::rdws_rslt_type             push_rslt
);

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   state_type                          state_ff,   state_in;
   logic [rdws_pkg::IDX_W-1:0]         head_ff,    head_in;
   logic [rdws_pkg::CNT_W-1:0]         count_ff,   count_in;
   logic [rdws_pkg::CNT_W-1:0]         iss_ff,     iss_in;
   rdws_pkg::rdws_op_type              op_ff,      op_in;
   logic signed [rdws_pkg::DATA_W-1:0] target_ff,  target_in;
   logic                               rd_pend_ff, rd_pend_in;
   logic                               rd_last_ff, rd_last_in;

   logic                               accept;
   logic                               is_full;
   logic                               more;
   logic                               consume;
   logic                               match;
   logic                               stop;
   logic                               issue;
   logic [rdws_pkg::IDX_W-1:0]         front_pos;

   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = count_ff == rdws_pkg::CNT_W'(rdws_pkg::CAPACITY);
   assign more       = iss_ff != count_ff;
   assign consume    = (state_ff == S_WALK) && rd_pend_ff && out_free;
   assign match      = rd_data == target_ff;
   assign stop       = consume && (op_ff == rdws_pkg::OP_SEARCH) && match;
   assign issue      = (state_ff == S_WALK) && more && (!rd_pend_ff || consume) && !stop;
   assign front_pos  = rdws_pkg::ring_pos(head_ff,
                                          rdws_pkg::CNT_W'(rdws_pkg::CAPACITY - 1));

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      iss_in     = iss_ff;
      op_in      = op_ff;
      target_in  = target_ff;
      rd_pend_in = rd_pend_ff;
      rd_last_in = rd_last_ff;
      mem_req         = '0;
      mem_req.wr_data = req_value;
      mem_req.rd_addr = rdws_pkg::ring_pos(head_ff, iss_ff);
      push_valid       = 1'b0;
      push_rslt.status = rdws_pkg::ST_INSERTED;
      push_rslt.data   = '0;
      push_rslt.last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               push_valid = 1'b1;
               op_in      = rdws_pkg::rdws_op_type'(req_op);
               target_in  = req_value;
               unique case (rdws_pkg::rdws_op_type'(req_op))
                  rdws_pkg::OP_INS_FRONT, rdws_pkg::OP_INS_BACK: begin
                     if (is_full) begin
                        push_rslt.status = rdws_pkg::ST_FULL;
                     end else begin
                        mem_req.wr_en = 1'b1;
                        count_in      = count_ff + rdws_pkg::CNT_W'(1);
                        if (rdws_pkg::rdws_op_type'(req_op) == rdws_pkg::OP_INS_FRONT) begin
                           head_in         = front_pos;
                           mem_req.wr_addr = front_pos;
                        end else begin
                           mem_req.wr_addr = rdws_pkg::ring_pos(head_ff, count_ff);
                        end
                     end
                  end
                  rdws_pkg::OP_LIST, rdws_pkg::OP_SEARCH: begin
                     if (count_ff == '0) begin
                        push_rslt.status = rdws_pkg::ST_EMPTY;
                     end else begin
                        push_valid = 1'b0;
                        state_in   = S_WALK;
                        iss_in     = '0;
                        rd_pend_in = 1'b0;
                     end
                  end
                  default: begin
                     push_valid = 1'b0;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (consume) begin
               rd_pend_in = 1'b0;
               if (op_ff == rdws_pkg::OP_LIST) begin
                  push_valid       = 1'b1;
                  push_rslt.status = rdws_pkg::ST_LISTED;
                  push_rslt.data   = rd_data;
                  push_rslt.last   = rd_last_ff;
                  if (rd_last_ff) begin
                     state_in = S_IDLE;
                  end
               end else if (match) begin
                  push_valid       = 1'b1;
                  push_rslt.status = rdws_pkg::ST_FOUND;
                  state_in         = S_IDLE;
               end else if (rd_last_ff) begin
                  push_valid       = 1'b1;
                  push_rslt.status = rdws_pkg::ST_NOT_FOUND;
                  state_in         = S_IDLE;
               end
            end
            if (issue) begin
               mem_req.rd_en = 1'b1;
               rd_pend_in    = 1'b1;
               iss_in        = iss_ff + rdws_pkg::CNT_W'(1);
               rd_last_in    = (iss_ff + rdws_pkg::CNT_W'(1)) == count_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
      end
      iss_ff     <= iss_in;
      op_ff      <= op_in;
      target_ff  <= target_in;
      rd_last_ff <= rd_last_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rdws_pkg::CNT_W'(rdws_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !rd_pend_ff)
      else $error("read pending while idle");

   a_walk_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |=> (count_ff == $past(count_ff)) && (head_ff == $past(head_ff)))
      else $error("ring changed during walk");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (iss_ff <= count_ff))
      else $error("walk ran past the stored entries");

endmodule

FILE: rtl/core/ring_deque_with_search.sv
// Ring deque with linear search over up to 64 signed 32-bit entries.
// Request channel: req_tuser carries the operation (insert front, insert
// back, list, search), req_tdata the value to insert or search for.
// Response channel: rsp_tuser carries the status, rsp_tdata the listed value
// (zero otherwise), rsp_tlast marks the final response of a request.
// Inserts and requests on an empty store give one response, registered in
// the cycle after the transfer. List reads one entry a cycle from the
// store's single read port while the receiver takes responses, and then
// gives one response per cycle on the same condition. Search compares one
// entry a cycle and answers by the last entry, earlier on a match.
// One request is in work at a time; req_tready drops during list and search.
// A stalled receiver holds the response register and pauses the read walk
// without loss. Reset empties the deque at once; entry contents stay
// undefined until written and are never read before that.
module ring_deque_with_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] data
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast
);

   rdws_pkg::rdws_mem_req_type         mem_req;
   logic signed [rdws_pkg::DATA_W-1:0] rd_data;
   logic                               push_valid;
   rdws_pkg::rdws_rslt_type            push_rslt;
   logic                               out_free;
   logic                               rsp_valid_ff;
   rdws_pkg::rdws_rslt_type            rsp_rslt_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   rdws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_value  (req_tdata),
      .out_free   (out_free),
      .rd_data    (rd_data),
      .mem_req    (mem_req),
      .push_valid (push_valid),
      .push_rslt  (push_rslt)
   );

   rdws_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (push_valid) begin
         rsp_rslt_ff <= push_rslt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_rslt_ff.data;
   assign rsp_tuser  = rsp_rslt_ff.status;
   assign rsp_tlast  = rsp_rslt_ff.last;

endmodule
